@@ rtl/core/tpcs_pkg.sv @@
// Shared types, constants and coefficient table for the three-phase current sense corrector.
// No dependencies; every other file in rtl/core imports this package.

package tpcs_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 20;
    localparam int OUT_W              = 22;
    localparam int GAIN_W             = 2;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 2;
    localparam int NUM_PHASES         = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SENSE_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CODE    = 1'b1;

    localparam logic [1:0] SEL_ALL  = 2'd0;
    localparam logic [1:0] SEL_NO_A = 2'd1;
    localparam logic [1:0] SEL_NO_B = 2'd2;
    localparam logic [1:0] SEL_NO_C = 2'd3;

    localparam longint MICRO_SCALE = 64'sd1000000;

    // Calibration matrices in millionths: [selection][output row][input column].
    localparam int CAL_MICRO [4][3][3] = '{
        '{ '{1001152, -3375, -3103}, '{2369, 1000665, -19126}, '{1234, 1595, 998166} },
        '{ '{0, 0, 0}, '{0, 998309, -21427}, '{0, 368, 996967} },
        '{ '{1004547, 0, 195}, '{0, 0, 0}, '{371, 0, 996975} },
        '{ '{1004346, -199, 0}, '{22060, 1020405, 0}, '{0, 0, 0} }
    };

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } t_lane_ctl;

    // Converts a coefficient to signed fixed point, rounding half away from zero.
    function automatic longint coef_q(input int sel, input int row, input int col,
                                      input int frac);
        longint micro;
        longint mag;
        longint q;
        micro = longint'(CAL_MICRO[sel][row][col]);
        mag   = (micro < 0) ? -micro : micro;
        q     = (mag * (longint'(1) << frac) + MICRO_SCALE / 2) / MICRO_SCALE;
        return (micro < 0) ? -q : q;
    endfunction

endpackage

@@ rtl/core/tpcs_front.sv @@
// Front stage: removes the reference offset, applies the gain shift and picks the matrix.
// Depends on tpcs_pkg.

module tpcs_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_sense_en,
    input  logic [tpcs_pkg::GAIN_W-1:0] i_gain,
    input  logic [SAMPLE_BITS-1:0]     i_ref,
    input  logic [SAMPLE_BITS-1:0]     i_ph [3],
    output logic signed [SAMPLE_BITS+4:0] o_x [3],
    output logic [1:0]                 o_sel,
    output logic [2:0]                 o_mask
);
    import tpcs_pkg::*;

    localparam int XW = SAMPLE_BITS + 5;
    localparam int DW = SAMPLE_BITS + 2;

    logic signed [XW-1:0] n_x [3];
    logic signed [XW-1:0] r_x [3];
    logic [1:0]           n_sel;
    logic [1:0]           r_sel;
    logic [2:0]           n_mask;
    logic [2:0]           r_mask;
    logic [GAIN_W-1:0]    w_shamt;

    assign w_shamt = GAIN_W'(3) - i_gain;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_diff
            logic signed [DW-1:0] w_d;
            assign w_d    = $signed({1'b0, i_ph[g], 1'b0}) - $signed({2'b00, i_ref});
            assign n_x[g] = XW'(w_d) <<< w_shamt;
        end
    endgenerate

    always_comb begin
        priority if (i_ph[0] == '0) begin
            n_sel = SEL_NO_A;
        end else if (i_ph[1] == '0) begin
            n_sel = SEL_NO_B;
        end else if (i_ph[2] == '0) begin
            n_sel = SEL_NO_C;
        end else begin
            n_sel = SEL_ALL;
        end
        n_mask = {n_sel != SEL_NO_C, n_sel != SEL_NO_B, n_sel != SEL_NO_A} & {3{i_sense_en}};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x    <= n_x;
            r_sel  <= n_sel;
            r_mask <= n_mask;
        end
    end

    assign o_x    = r_x;
    assign o_sel  = r_sel;
    assign o_mask = r_mask;

endmodule

@@ rtl/core/tpcs_lane.sv @@
// One matrix row: three coefficient products, then sum, rounding shift and saturation.
// Depends on tpcs_pkg for the coefficient table and lane control struct.

module tpcs_lane #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 20,
    parameter int LANE           = 0
) (
    input  logic                           i_clk,
    input  tpcs_pkg::t_lane_ctl            i_ctl,
    input  logic [1:0]                     i_sel,
    input  logic signed [SAMPLE_BITS+4:0]  i_x [3],
    output logic signed [tpcs_pkg::OUT_W-1:0] o_cur
);
    import tpcs_pkg::*;

    localparam int XW = SAMPLE_BITS + 5;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = XW + CW;
    localparam int SW = PW + 2;
    localparam int RW = SW + 1;
    localparam logic signed [RW-1:0] ROUND  = RW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic signed [CW-1:0]    w_coef [3];
    logic signed [PW-1:0]    n_prod [3];
    logic signed [PW-1:0]    r_prod [3];
    logic signed [RW-1:0]    w_sum;
    logic signed [RW-1:0]    w_shr;
    logic signed [OUT_W-1:0] n_cur;
    logic signed [OUT_W-1:0] r_cur;

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_col
            always_comb begin
                unique case (i_sel)
                    SEL_ALL:  w_coef[c] = CW'(coef_q(0, LANE, c, COEF_FRAC_BITS));
                    SEL_NO_A: w_coef[c] = CW'(coef_q(1, LANE, c, COEF_FRAC_BITS));
                    SEL_NO_B: w_coef[c] = CW'(coef_q(2, LANE, c, COEF_FRAC_BITS));
                    SEL_NO_C: w_coef[c] = CW'(coef_q(3, LANE, c, COEF_FRAC_BITS));
                endcase
            end
            assign n_prod[c] = PW'(w_coef[c]) * PW'(i_x[c]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
    end

    assign w_sum = RW'(r_prod[0]) + RW'(r_prod[1]) + RW'(r_prod[2]) + ROUND;
    assign w_shr = w_sum >>> COEF_FRAC_BITS;

    always_comb begin
        priority if (w_shr > SAT_HI) begin
            n_cur = SAT_HI[OUT_W-1:0];
        end else if (w_shr < SAT_LO) begin
            n_cur = SAT_LO[OUT_W-1:0];
        end else begin
            n_cur = w_shr[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_cur <= n_cur;
        end
    end

    assign o_cur = r_cur;

endmodule

@@ rtl/core/tpcs_merge.sv @@
// Merge stage: gathers the three lane results into the output word register.
// Depends on tpcs_pkg; currents of phases that were not computed read as zero.

module tpcs_merge (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic [2:0]                        i_mask,
    input  logic signed [tpcs_pkg::OUT_W-1:0] i_cur [3],
    output logic signed [tpcs_pkg::OUT_W-1:0] o_cur [3],
    output logic [2:0]                        o_flags
);
    import tpcs_pkg::*;

    logic signed [OUT_W-1:0] n_cur [3];
    logic signed [OUT_W-1:0] r_cur [3];
    logic [2:0]              r_flags;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cur[k] = i_mask[k] ? i_cur[k] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur   <= n_cur;
            r_flags <= i_mask;
        end
    end

    assign o_cur   = r_cur;
    assign o_flags = r_flags;

endmodule

@@ rtl/core/three_phase_current_sense_correct_top.sv @@
// Top level of the three-phase current sense corrector: config registers and pipeline control.
// Depends on tpcs_pkg, tpcs_front, tpcs_lane and tpcs_merge.
//
//   Channel   Handshake             Payload
//   input     i_valid / o_stall     i_ref_sample, i_phase_a/b/c_sample
//   output    o_valid / i_stall     o_current_a/b/c, o_valid_a/b/c
//   config    i_cfg_we              i_cfg_idx, i_cfg_data
//
// One word is accepted every cycle while o_stall is low; each accepted word passes through
// the front register, the lane multiplier register, the lane sum register and the output
// register in that order. Reset is synchronous and clears the config registers and the
// stage valid bits. A stall holds the output word and fills the pipeline stages before the
// input stalls.

module three_phase_current_sense_correct_top #(
    parameter int SAMPLE_BITS    = tpcs_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tpcs_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tpcs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tpcs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [SAMPLE_BITS-1:0]               i_ref_sample,
    input  logic [SAMPLE_BITS-1:0]               i_phase_a_sample,
    input  logic [SAMPLE_BITS-1:0]               i_phase_b_sample,
    input  logic [SAMPLE_BITS-1:0]               i_phase_c_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [tpcs_pkg::OUT_W-1:0]    o_current_a,
    output logic signed [tpcs_pkg::OUT_W-1:0]    o_current_b,
    output logic signed [tpcs_pkg::OUT_W-1:0]    o_current_c,
    output logic                                 o_valid_a,
    output logic                                 o_valid_b,
    output logic                                 o_valid_c
);
    import tpcs_pkg::*;

    localparam int XW = SAMPLE_BITS + 5;

    logic              r_sense_en;
    logic [GAIN_W-1:0] r_gain;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_v4;
    logic [2:0]        r_p2_mask;
    logic [2:0]        r_p3_mask;
    logic              w_rdy1;
    logic              w_rdy2;
    logic              w_rdy3;
    logic              w_rdy4;
    t_lane_ctl         w_ctl;

    logic [SAMPLE_BITS-1:0]  w_ph [3];
    logic signed [XW-1:0]    w_x [3];
    logic [1:0]              w_sel;
    logic [2:0]              w_mask;
    logic signed [OUT_W-1:0] w_lane_cur [3];
    logic signed [OUT_W-1:0] w_out_cur [3];
    logic [2:0]              w_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense_en <= 1'b0;
            r_gain     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SENSE_ENABLE: r_sense_en <= i_cfg_data[0];
                REG_GAIN_CODE:    r_gain     <= i_cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    assign w_rdy4 = !r_v4 || !i_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_p2_mask <= w_mask;
        end
        if (w_rdy3) begin
            r_p3_mask <= r_p2_mask;
        end
    end

    assign w_ph[0] = i_phase_a_sample;
    assign w_ph[1] = i_phase_b_sample;
    assign w_ph[2] = i_phase_c_sample;

    tpcs_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_load     (w_rdy1 && i_valid),
        .i_sense_en (r_sense_en),
        .i_gain     (r_gain),
        .i_ref      (i_ref_sample),
        .i_ph       (w_ph),
        .o_x        (w_x),
        .o_sel      (w_sel),
        .o_mask     (w_mask)
    );

    assign w_ctl.mul_en = w_rdy2;
    assign w_ctl.sum_en = w_rdy3;

    genvar l;
    generate
        for (l = 0; l < NUM_PHASES; l++) begin : g_lane
            tpcs_lane #(
                .SAMPLE_BITS    (SAMPLE_BITS),
                .COEF_FRAC_BITS (COEF_FRAC_BITS),
                .LANE           (l)
            ) u_lane (
                .i_clk (i_clk),
                .i_ctl (w_ctl),
                .i_sel (w_sel),
                .i_x   (w_x),
                .o_cur (w_lane_cur[l])
            );
        end
    endgenerate

    tpcs_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (w_rdy4),
        .i_mask  (r_p3_mask),
        .i_cur   (w_lane_cur),
        .o_cur   (w_out_cur),
        .o_flags (w_flags)
    );

    assign o_valid     = r_v4;
    assign o_current_a = w_out_cur[0];
    assign o_current_b = w_out_cur[1];
    assign o_current_c = w_out_cur[2];
    assign o_valid_a   = w_flags[0];
    assign o_valid_b   = w_flags[1];
    assign o_valid_c   = w_flags[2];

`ifndef ASSERT_OFF
    a_accept_fills_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("Accepted word did not reach the front stage.");

    a_flag_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(w_flags) == 0 || $countones(w_flags) >= 2))
        else $error("More than one phase marked as not computed.");

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (!o_valid_a || !o_valid_b || !o_valid_c)) |->
        ((o_valid_a || o_current_a == '0) && (o_valid_b || o_current_b == '0) &&
         (o_valid_c || o_current_c == '0)))
        else $error("A current not computed is not zero.");
`endif

endmodule

@@ bench/tpcs_checker.sv @@
// Checker for the three-phase current sense corrector: watches the config port and both channels.
// Predicts each output word from its own calibration table and compares it field by field.
// Depends on tpcs_pkg for widths and register indexes.

module tpcs_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tpcs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tpcs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [tpcs_pkg::SAMPLE_BITS_DEF-1:0] i_ref_sample,
    input  logic [tpcs_pkg::SAMPLE_BITS_DEF-1:0] i_phase_a_sample,
    input  logic [tpcs_pkg::SAMPLE_BITS_DEF-1:0] i_phase_b_sample,
    input  logic [tpcs_pkg::SAMPLE_BITS_DEF-1:0] i_phase_c_sample,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [tpcs_pkg::OUT_W-1:0]    i_current_a,
    input  logic signed [tpcs_pkg::OUT_W-1:0]    i_current_b,
    input  logic signed [tpcs_pkg::OUT_W-1:0]    i_current_c,
    input  logic                                 i_valid_a,
    input  logic                                 i_valid_b,
    input  logic                                 i_valid_c,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_checked
);

    import tpcs_pkg::*;

    localparam int FRAC = COEF_FRAC_BITS_DEF;
    localparam longint CUR_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint CUR_MIN = -(longint'(1) << (OUT_W - 1));

    typedef struct {
        logic signed [OUT_W-1:0] cur [NUM_PHASES];
        logic                    vld [NUM_PHASES];
    } t_phase_currents;

    // Calibration in millionths: [unsensed phase: none, A, B, C][output phase][input phase].
    localparam int CAL_MILLIONTHS [4][3][3] = '{
        '{ '{1001152, -3375, -3103}, '{2369, 1000665, -19126}, '{1234, 1595, 998166} },
        '{ '{0, 0, 0}, '{0, 998309, -21427}, '{0, 368, 996967} },
        '{ '{1004547, 0, 195}, '{0, 0, 0}, '{371, 0, 996975} },
        '{ '{1004346, -199, 0}, '{22060, 1020405, 0}, '{0, 0, 0} }
    };

    longint          cal_q [4][3][3];
    t_phase_currents expected_currents [$];
    t_phase_currents seen;
    t_phase_currents want;
    logic            sense_on;
    logic [1:0]      gain_sel;
    int              fail_count;
    int              checked;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    function automatic longint millionths_to_q(input int m);
        longint mag;
        longint q;
        mag = (m < 0) ? -longint'(m) : longint'(m);
        q   = (mag * (longint'(1) << FRAC) + 500000) / 1000000;
        return (m < 0) ? -q : q;
    endfunction

    function automatic t_phase_currents predict_currents(input logic [15:0] vref,
                                                         input logic [15:0] va,
                                                         input logic [15:0] vb,
                                                         input logic [15:0] vc);
        t_phase_currents res;
        longint          v [3];
        longint          x [3];
        longint          acc;
        longint          r;
        int              unsensed;
        v[0] = longint'(va);
        v[1] = longint'(vb);
        v[2] = longint'(vc);
        for (int i = 0; i < 3; i++) begin
            x[i]       = (2 * v[i] - longint'(vref)) * (longint'(1) << (3 - int'(gain_sel)));
            res.cur[i] = '0;
            res.vld[i] = 1'b0;
        end
        if (!sense_on) begin
            return res;
        end
        if (v[0] == 0) begin
            unsensed = 1;
        end else if (v[1] == 0) begin
            unsensed = 2;
        end else if (v[2] == 0) begin
            unsensed = 3;
        end else begin
            unsensed = 0;
        end
        for (int i = 0; i < 3; i++) begin
            if (unsensed != i + 1) begin
                acc = 0;
                for (int j = 0; j < 3; j++) begin
                    acc += cal_q[unsensed][i][j] * x[j];
                end
                r = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
                if (r > CUR_MAX) begin
                    r = CUR_MAX;
                end
                if (r < CUR_MIN) begin
                    r = CUR_MIN;
                end
                res.cur[i] = r[OUT_W-1:0];
                res.vld[i] = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic compare_currents(input t_phase_currents exp_w, input t_phase_currents act_w);
        string names [3];
        names = '{"a", "b", "c"};
        for (int i = 0; i < 3; i++) begin
            if (act_w.cur[i] !== exp_w.cur[i]) begin
                $display("%0t: current_%s expected %0d got %0d", $time, names[i],
                         exp_w.cur[i], act_w.cur[i]);
                fail_count++;
            end
            if (act_w.vld[i] !== exp_w.vld[i]) begin
                $display("%0t: valid_%s expected %0b got %0b", $time, names[i],
                         exp_w.vld[i], act_w.vld[i]);
                fail_count++;
            end
        end
    endtask

    initial begin
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cal_q[s][i][j] = millionths_to_q(CAL_MILLIONTHS[s][i][j]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sense_on = 1'b0;
            gain_sel = 2'd0;
            expected_currents.delete();
        end else begin
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                expected_currents.push_back(predict_currents(i_ref_sample, i_phase_a_sample,
                                                             i_phase_b_sample,
                                                             i_phase_c_sample));
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                seen.cur = '{i_current_a, i_current_b, i_current_c};
                seen.vld = '{i_valid_a, i_valid_b, i_valid_c};
                if (expected_currents.size() == 0) begin
                    $display("%0t: output word with no expected word waiting", $time);
                    fail_count++;
                end else begin
                    want = expected_currents.pop_front();
                    compare_currents(want, seen);
                end
                checked++;
            end
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_idx == REG_SENSE_ENABLE) begin
                    sense_on = i_cfg_data[0];
                end else if (i_cfg_idx == REG_GAIN_CODE) begin
                    gain_sel = i_cfg_data[1:0];
                end
            end
        end
        o_pending = expected_currents.size();
    end

endmodule

@@ bench/three_phase_current_sense_correct_top_tb.sv @@
// Testbench top for the three-phase current sense corrector: clock, reset, stimulus and verdict.
// Depends on tpcs_pkg, the block three_phase_current_sense_correct_top and tpcs_checker.

module three_phase_current_sense_correct_top_tb;

    import tpcs_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_WORDS = 250;

    localparam logic [15:0] DIRECTED [16][4] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'hFFFF, 16'h0001, 16'h0001, 16'h0001},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF},
        '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
        '{16'h8000, 16'h0000, 16'h0000, 16'h1234},
        '{16'h8000, 16'h4321, 16'h0000, 16'h0000},
        '{16'h0001, 16'h0000, 16'h7FFF, 16'h0000},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
        '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
        '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000},
        '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
        '{16'h7FFF, 16'hFFFF, 16'h8001, 16'hFFFE}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_stall;
    logic [SB-1:0]             i_ref_sample;
    logic [SB-1:0]             i_phase_a_sample;
    logic [SB-1:0]             i_phase_b_sample;
    logic [SB-1:0]             i_phase_c_sample;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [OUT_W-1:0]   o_current_a;
    logic signed [OUT_W-1:0]   o_current_b;
    logic signed [OUT_W-1:0]   o_current_c;
    logic                      o_valid_a;
    logic                      o_valid_b;
    logic                      o_valid_c;

    int fail_count;
    int pending;
    int checked;
    int idle_cycles;
    int words_sent;
    int settings_run;

    three_phase_current_sense_correct_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_ref_sample    (i_ref_sample),
        .i_phase_a_sample(i_phase_a_sample),
        .i_phase_b_sample(i_phase_b_sample),
        .i_phase_c_sample(i_phase_c_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_current_a     (o_current_a),
        .o_current_b     (o_current_b),
        .o_current_c     (o_current_c),
        .o_valid_a       (o_valid_a),
        .o_valid_b       (o_valid_b),
        .o_valid_c       (o_valid_c)
    );

    tpcs_checker current_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_ref_sample    (i_ref_sample),
        .i_phase_a_sample(i_phase_a_sample),
        .i_phase_b_sample(i_phase_b_sample),
        .i_phase_c_sample(i_phase_c_sample),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_current_a     (o_current_a),
        .i_current_b     (o_current_b),
        .i_current_c     (o_current_c),
        .i_valid_a       (o_valid_a),
        .i_valid_b       (o_valid_b),
        .i_valid_c       (o_valid_c),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SB-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 14) begin
            return '1;
        end else if (r < 18) begin
            return SB'(1);
        end
        return SB'($urandom_range(0, 65535));
    endfunction

    task automatic wait_drained();
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_config(input logic en, input logic [1:0] gain);
        wait_drained();
        repeat (6) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SENSE_ENABLE;
        i_cfg_data <= CFG_DATA_W'(en);
        @(negedge i_clk);
        i_cfg_idx  <= REG_GAIN_CODE;
        i_cfg_data <= gain;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        settings_run++;
    endtask

    task automatic send_word(input logic [SB-1:0] vref, input logic [SB-1:0] va,
                             input logic [SB-1:0] vb, input logic [SB-1:0] vc);
        i_valid          <= 1'b1;
        i_ref_sample     <= vref;
        i_phase_a_sample <= va;
        i_phase_b_sample <= vb;
        i_phase_c_sample <= vc;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int count);
        int gap;
        for (int n = 0; n < count; n++) begin
            send_word(pick_sample(), pick_sample(), pick_sample(), pick_sample());
            if (n == count / 2) begin
                i_valid <= 1'b0;
                do begin
                    @(negedge i_clk);
                end while (pending != 0);
            end else begin
                gap = pick_gap(((n / 40) % 4) == 1);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int r;
        int len;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end else begin
                len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                i_stall <= 1'b1;
                repeat (len) @(negedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d cycles with no word moving.", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int gap;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_SENSE_ENABLE;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_ref_sample     = '0;
        i_phase_a_sample = '0;
        i_phase_b_sample = '0;
        i_phase_c_sample = '0;
        words_sent       = 0;
        settings_run     = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_config(1'b1, 2'd0);
        for (int n = 0; n < 16; n++) begin
            send_word(DIRECTED[n][0], DIRECTED[n][1], DIRECTED[n][2], DIRECTED[n][3]);
            gap = pick_gap(1'b0);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        write_config(1'b1, 2'd3);
        run_random_phase(PHASE_WORDS);
        write_config(1'b0, 2'd2);
        run_random_phase(PHASE_WORDS);
        write_config(1'b1, 2'd1);
        run_random_phase(PHASE_WORDS);
        write_config(1'b1, 2'd2);
        run_random_phase(PHASE_WORDS);
        write_config(1'b1, 2'd0);
        run_random_phase(PHASE_WORDS);
        write_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        run_random_phase(PHASE_WORDS);

        wait_drained();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d words and checked %0d results over %0d register settings,",
                 words_sent, checked, settings_run);
        $display("covering sense disabled, every gain code and each unsensed phase.");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ three_phase_current_sense_correct_top.f @@
rtl/core/tpcs_pkg.sv
rtl/core/tpcs_front.sv
rtl/core/tpcs_lane.sv
rtl/core/tpcs_merge.sv
rtl/core/three_phase_current_sense_correct_top.sv
bench/tpcs_checker.sv
bench/three_phase_current_sense_correct_top_tb.sv
